// File: rtl/ttcb_pkg.sv
package ttcb_pkg;

    localparam int COLUMNS   = 32;
    localparam int GRID_ROWS = 16;

    localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int ROW_XW = ROW_W + 1;
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int FILL_W = $clog2(COLUMNS + 1);
    localparam int DEPTH  = GRID_ROWS * COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int CHAR_W   = 8;
    localparam int OROW_W   = 4;
    localparam int OCOL_W   = 5;

    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } ttcb_cmd_t;

endpackage

// File: rtl/ttcb_ram.sv
module ttcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/ttcb_ctrl.sv
module ttcb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output ttcb_pkg::ttcb_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LOAD = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: state_next = S_LOAD;
            S_LOAD: state_next = S_OUT;
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = (state_reg == S_OUT);
    assign cmd.capture = s_valid && (state_reg == S_IDLE);
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.load    = (state_reg == S_LOAD);

endmodule

// File: rtl/ttcb_dpath.sv
module ttcb_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ttcb_pkg::ttcb_cmd_t                 cmd,
    input  logic                                s_op,
    input  logic [ttcb_pkg::CHAR_W-1:0]         s_char_code,
    input  logic [3:0]                          s_read_row,
    input  logic [4:0]                          s_read_col,
    output logic [ttcb_pkg::CHAR_W-1:0]         m_cell_char,
    output logic [ttcb_pkg::OROW_W-1:0]         m_cursor_row,
    output logic [ttcb_pkg::OCOL_W-1:0]         m_cursor_col,
    output logic                                m_scrolled
);

    localparam int ROW_W  = ttcb_pkg::ROW_W;
    localparam int ROW_XW = ttcb_pkg::ROW_XW;
    localparam int COL_W  = ttcb_pkg::COL_W;
    localparam int FILL_W = ttcb_pkg::FILL_W;
    localparam int ADDR_W = ttcb_pkg::ADDR_W;
    localparam int CHAR_W = ttcb_pkg::CHAR_W;
    localparam int NROWS  = ttcb_pkg::GRID_ROWS;
    localparam int NCOLS  = ttcb_pkg::COLUMNS;

    function automatic logic [ROW_W-1:0] phys_row(
        input logic [ROW_W-1:0] lrow,
        input logic [ROW_W-1:0] base
    );
        logic [ROW_XW-1:0] sum;
        sum = ROW_XW'(lrow) + ROW_XW'(base);
        if (sum >= ROW_XW'(NROWS)) begin
            sum = sum - ROW_XW'(NROWS);
        end
        return ROW_W'(sum);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] prow,
        input logic [COL_W-1:0] col
    );
        return ADDR_W'(ADDR_W'(prow) * ADDR_W'(NCOLS) + ADDR_W'(col));
    endfunction

    logic              op_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [3:0]        rrow_reg;
    logic [4:0]        rcol_reg;

    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  base_reg, base_next;
    logic [FILL_W-1:0] fill_reg [NROWS];
    logic [FILL_W-1:0] fill_next [NROWS];
    logic              hit_reg, hit_next;
    logic              scr_reg, scr_next;
    logic [CHAR_W-1:0] cell_reg, cell_next;

    logic [ROW_W-1:0]  cur_phys;
    logic [ROW_W-1:0]  rd_phys;
    logic              rd_in_grid;
    logic [ROW_XW-1:0] row_tmp;
    logic [FILL_W-1:0] col_tmp;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    assign cur_phys   = phys_row(cur_row_reg, base_reg);
    assign rd_phys    = phys_row(ROW_W'(rrow_reg), base_reg);
    assign rd_in_grid = (int'(rrow_reg) < NROWS) && (int'(rcol_reg) < NCOLS);
    assign ram_waddr  = cell_addr(cur_phys, cur_col_reg);
    assign ram_raddr  = cell_addr(rd_phys, COL_W'(rcol_reg));

    ttcb_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(ttcb_pkg::DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(char_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        base_next    = base_reg;
        fill_next    = fill_reg;
        hit_next     = hit_reg;
        scr_next     = scr_reg;
        cell_next    = cell_reg;
        ram_we       = 1'b0;
        row_tmp      = ROW_XW'(cur_row_reg);
        col_tmp      = FILL_W'(cur_col_reg);

        if (cmd.exec) begin
            scr_next = 1'b0;
            hit_next = 1'b0;
            if (op_reg == ttcb_pkg::OP_WRITE) begin
                if (char_reg == ttcb_pkg::CH_LF) begin
                    row_tmp = row_tmp + ROW_XW'(1);
                    col_tmp = '0;
                end else if (char_reg != ttcb_pkg::CH_CR) begin
                    ram_we              = 1'b1;
                    col_tmp             = col_tmp + FILL_W'(1);
                    fill_next[cur_phys] = col_tmp;
                end
                if (col_tmp == FILL_W'(NCOLS)) begin
                    col_tmp = '0;
                    row_tmp = row_tmp + ROW_XW'(1);
                end
                if (row_tmp == ROW_XW'(NROWS)) begin
                    // oldest row becomes the new, empty bottom row
                    row_tmp             = ROW_XW'(NROWS - 1);
                    fill_next[base_reg] = '0;
                    base_next           = (base_reg == ROW_W'(NROWS - 1)) ? '0
                                          : base_reg + ROW_W'(1);
                    scr_next            = 1'b1;
                end
                cur_row_next = ROW_W'(row_tmp);
                cur_col_next = COL_W'(col_tmp);
            end else begin
                hit_next = rd_in_grid && (int'(rcol_reg) < int'(fill_reg[rd_phys]));
            end
        end

        if (cmd.load) begin
            cell_next = ((op_reg == ttcb_pkg::OP_READ) && hit_reg) ? ram_rdata : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_op;
            char_reg <= s_char_code;
            rrow_reg <= s_read_row;
            rcol_reg <= s_read_col;
        end
        hit_reg  <= hit_next;
        cell_reg <= cell_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            base_reg    <= '0;
            scr_reg     <= 1'b0;
            for (int i = 0; i < NROWS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            base_reg    <= base_next;
            scr_reg     <= scr_next;
            fill_reg    <= fill_next;
        end
    end

    assign m_cell_char  = cell_reg;
    assign m_cursor_row = ttcb_pkg::OROW_W'(cur_row_reg);
    assign m_cursor_col = ttcb_pkg::OCOL_W'(cur_col_reg);
    assign m_scrolled   = scr_reg;

endmodule

// File: rtl/text_terminal_char_buffer_core.sv
// text-mode character grid with a cursor and scroll-up
// input channel (s_valid/s_ready): s_op 0 prints s_char_code at the cursor,
//   s_op 1 reads the cell at s_read_row/s_read_col; s_last_char is carried
//   by the sender only and does not change the grid
// result channel (m_valid/m_ready): one result per request with the read
//   cell (zero for a print), the cursor after the request and a scroll flag
// sequence: an accepted request steps the controller through S_EXEC and
//   S_LOAD to S_OUT, where m_valid rises; one request is in flight at a
//   time, so no new request is taken until the result has been taken
// scroll takes no extra state: the rows form a ring with a rotating top row
//   and a per-row fill count, so the recycled bottom row reads as zero
// reset: synchronous active-low aresetn; the whole grid reads as zero and the
//   cursor is at row 0, column 0 as soon as reset is released, with no
//   clearing pass
// stall: while m_ready is low the result holds on the m_ ports and s_ready
//   stays low, so no request is lost or taken early
module text_terminal_char_buffer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_char_code,
    input  logic [3:0] s_read_row,
    input  logic [4:0] s_read_col,
    input  logic       s_last_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_cell_char,
    output logic [3:0] m_cursor_row,
    output logic [4:0] m_cursor_col,
    output logic       m_scrolled
);

    ttcb_pkg::ttcb_cmd_t cmd;

    ttcb_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd)
    );

    ttcb_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_op        (s_op),
        .s_char_code (s_char_code),
        .s_read_row  (s_read_row),
        .s_read_col  (s_read_col),
        .m_cell_char (m_cell_char),
        .m_cursor_row(m_cursor_row),
        .m_cursor_col(m_cursor_col),
        .m_scrolled  (m_scrolled)
    );

endmodule

// File: bench/tb_text_terminal_char_buffer_core.sv
`timescale 1ns / 1ps

module tb_text_terminal_char_buffer_core;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic [3:0] row;
        logic [4:0] col;
        logic       last;
    } request_t;

    typedef struct packed {
        logic [7:0] cchar;
        logic [3:0] crow;
        logic [4:0] ccol;
        logic       scr;
    } result_t;

    typedef struct packed {
        request_t req;
        int       repeats;
        bit       typed;
        result_t  want;
    } script_row_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_CHOKED
    } rx_mode_t;

    localparam int RANDOM_ITEMS = 1550;
    localparam int TAIL_CYCLES  = 20;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_op;
    logic [7:0] s_char_code;
    logic [3:0] s_read_row;
    logic [4:0] s_read_col;
    logic       s_last_char;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_cell_char;
    logic [3:0] m_cursor_row;
    logic [4:0] m_cursor_col;
    logic       m_scrolled;

    text_terminal_char_buffer_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_char_code  (s_char_code),
        .s_read_row   (s_read_row),
        .s_read_col   (s_read_col),
        .s_last_char  (s_last_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_char  (m_cell_char),
        .m_cursor_row (m_cursor_row),
        .m_cursor_col (m_cursor_col),
        .m_scrolled   (m_scrolled)
    );

    logic [7:0] screen [ttcb_pkg::GRID_ROWS][ttcb_pkg::COLUMNS];
    int         cur_row;
    int         cur_col;
    result_t    results_due [$];
    int         mismatches;
    int         burst_left;
    script_row_t script [$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    function automatic result_t print_or_read(request_t req);
        result_t r;
        r = '0;
        if (req.op == ttcb_pkg::OP_READ) begin
            if (req.row < ttcb_pkg::GRID_ROWS && req.col < ttcb_pkg::COLUMNS)
                r.cchar = screen[req.row][req.col];
        end else begin
            if (req.ch == ttcb_pkg::CH_LF) begin
                cur_row++;
                cur_col = 0;
            end else if (req.ch != ttcb_pkg::CH_CR) begin
                if (cur_row < ttcb_pkg::GRID_ROWS && cur_col < ttcb_pkg::COLUMNS)
                    screen[cur_row][cur_col] = req.ch;
                cur_col++;
            end
            if (cur_col >= ttcb_pkg::COLUMNS) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= ttcb_pkg::GRID_ROWS) begin
                for (int y = 0; y < ttcb_pkg::GRID_ROWS - 1; y++)
                    for (int x = 0; x < ttcb_pkg::COLUMNS; x++)
                        screen[y][x] = screen[y + 1][x];
                for (int x = 0; x < ttcb_pkg::COLUMNS; x++)
                    screen[ttcb_pkg::GRID_ROWS - 1][x] = '0;
                cur_row = ttcb_pkg::GRID_ROWS - 1;
                r.scr = 1'b1;
            end
        end
        r.crow = cur_row[3:0];
        r.ccol = cur_col[4:0];
        return r;
    endfunction

    function automatic request_t wr(logic [7:0] ch, logic last);
        request_t q;
        q.op   = ttcb_pkg::OP_WRITE;
        q.ch   = ch;
        q.row  = 4'($urandom_range(0, 15));
        q.col  = 5'($urandom_range(0, 31));
        q.last = last;
        return q;
    endfunction

    function automatic request_t rd(logic [3:0] row, logic [4:0] col, logic last);
        request_t q;
        q.op   = ttcb_pkg::OP_READ;
        q.ch   = 8'($urandom_range(0, 255));
        q.row  = row;
        q.col  = col;
        q.last = last;
        return q;
    endfunction

    function automatic script_row_t checked_row(request_t req, int repeats);
        script_row_t s;
        s.req     = req;
        s.repeats = repeats;
        s.typed   = 1'b0;
        s.want    = '0;
        return s;
    endfunction

    function automatic script_row_t typed_row(request_t req, result_t want);
        script_row_t s;
        s.req     = req;
        s.repeats = 1;
        s.typed   = 1'b1;
        s.want    = want;
        return s;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // bursts of requests with random gaps between them
    task automatic send_request(request_t req, bit typed, result_t want);
        result_t predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 12));
        end
        burst_left--;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_op        <= req.op;
        s_char_code <= req.ch;
        s_read_row  <= req.row;
        s_read_col  <= req.col;
        s_last_char <= req.last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = print_or_read(req);
        results_due.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        idle_cycles(1);
        while (results_due.size() != 0)
            @(posedge aclk);
    endtask

    // random byte for console text: mostly printable, some control codes
    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 68)
            return 8'($urandom_range(8'h20, 8'h7e));
        else if (pick < 78)
            return ttcb_pkg::CH_LF;
        else if (pick < 83)
            return ttcb_pkg::CH_CR;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = results_due.pop_front();
                if (m_cell_char !== want.cchar)
                    report_mismatch($sformatf("cell_char got %0d want %0d",
                                              m_cell_char, want.cchar));
                if (m_cursor_row !== want.crow)
                    report_mismatch($sformatf("cursor_row got %0d want %0d",
                                              m_cursor_row, want.crow));
                if (m_cursor_col !== want.ccol)
                    report_mismatch($sformatf("cursor_col got %0d want %0d",
                                              m_cursor_col, want.ccol));
                if (m_scrolled !== want.scr)
                    report_mismatch($sformatf("scrolled got %0d want %0d",
                                              m_scrolled, want.scr));
            end
        end
    end

    // receiver stall pattern
    initial begin
        rx_mode_t mode;
        int       len;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            len  = $urandom_range(5, 60);
            repeat (len) begin
                @(negedge aclk);
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
                    default:   m_ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    initial begin
        int      sent;
        int      call_len;
        request_t q;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_op        = ttcb_pkg::OP_WRITE;
        s_char_code = '0;
        s_read_row  = '0;
        s_read_col  = '0;
        s_last_char = 1'b0;
        mismatches  = 0;
        burst_left  = 0;
        cur_row     = 0;
        cur_col     = 0;
        for (int y = 0; y < ttcb_pkg::GRID_ROWS; y++)
            for (int x = 0; x < ttcb_pkg::COLUMNS; x++)
                screen[y][x] = '0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        script.push_back(typed_row(rd(4'd0, 5'd0, 1'b0), '{8'd0, 4'd0, 5'd0, 1'b0}));
        script.push_back(typed_row(rd(4'd15, 5'd31, 1'b1), '{8'd0, 4'd0, 5'd0, 1'b0}));
        script.push_back(typed_row(wr(8'h48, 1'b0), '{8'd0, 4'd0, 5'd1, 1'b0}));
        script.push_back(typed_row(wr(ttcb_pkg::CH_CR, 1'b0), '{8'd0, 4'd0, 5'd1, 1'b0}));
        script.push_back(checked_row(wr(8'hff, 1'b0), 1));
        script.push_back(checked_row(wr(8'h00, 1'b1), 1));
        script.push_back(checked_row(rd(4'd0, 5'd0, 1'b0), 1));
        script.push_back(checked_row(rd(4'd0, 5'd1, 1'b1), 1));
        script.push_back(checked_row(rd(4'd0, 5'd2, 1'b0), 1));
        script.push_back(typed_row(wr(ttcb_pkg::CH_LF, 1'b1), '{8'd0, 4'd1, 5'd0, 1'b0}));
        // fill a row to the last column, then wrap
        script.push_back(checked_row(wr(8'h41, 1'b0), 31));
        script.push_back(checked_row(wr(8'h7e, 1'b1), 1));
        script.push_back(checked_row(rd(4'd1, 5'd31, 1'b0), 1));
        script.push_back(checked_row(wr(ttcb_pkg::CH_CR, 1'b0), 1));
        // walk down to the last row and scroll on newline
        script.push_back(checked_row(wr(ttcb_pkg::CH_LF, 1'b0), 13));
        script.push_back(checked_row(wr(8'h55, 1'b0), 5));
        script.push_back(checked_row(wr(ttcb_pkg::CH_LF, 1'b1), 1));
        script.push_back(checked_row(rd(4'd15, 5'd0, 1'b0), 1));
        script.push_back(checked_row(rd(4'd14, 5'd0, 1'b0), 1));
        script.push_back(checked_row(rd(4'd0, 5'd0, 1'b0), 1));
        // wrap at the end of the last row scrolls too
        script.push_back(checked_row(wr(8'h01, 1'b0), 32));
        script.push_back(checked_row(rd(4'd15, 5'd31, 1'b1), 1));
        script.push_back(checked_row(rd(4'd14, 5'd31, 1'b0), 1));
        script.push_back(checked_row(wr(ttcb_pkg::CH_CR, 1'b1), 1));
        script.push_back(checked_row(wr(ttcb_pkg::CH_LF, 1'b0), 1));

        foreach (script[i])
            repeat (script[i].repeats)
                send_request(script[i].req, script[i].typed, script[i].want);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent > RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 45)
                drain_results();
            case ($urandom_range(0, 9))
                0: begin
                    // noise
                    q.op   = 1'($urandom_range(0, 1));
                    q.ch   = 8'($urandom_range(0, 255));
                    q.row  = 4'($urandom_range(0, 15));
                    q.col  = 5'($urandom_range(0, 31));
                    q.last = 1'($urandom_range(0, 1));
                    send_request(q, 1'b0, '0);
                    sent++;
                end
                1, 2: begin
                    repeat ($urandom_range(1, 4)) begin
                        send_request(rd(4'($urandom_range(0, 15)),
                                        5'($urandom_range(0, 31)),
                                        1'($urandom_range(0, 1))), 1'b0, '0);
                        sent++;
                    end
                end
                default: begin
                    // one print call
                    call_len = $urandom_range(1, 40);
                    for (int k = 0; k < call_len; k++) begin
                        send_request(wr(text_byte(), k == call_len - 1), 1'b0, '0);
                        sent++;
                    end
                end
            endcase
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (results_due.size() != 0)
            report_mismatch("results still pending at end of run");
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
rtl/ttcb_pkg.sv
rtl/ttcb_ram.sv
rtl/ttcb_ctrl.sv
rtl/ttcb_dpath.sv
rtl/text_terminal_char_buffer_core.sv
bench/tb_text_terminal_char_buffer_core.sv
